// ===== hdl/cpk_pkg.sv =====
package cpk_pkg;

    localparam int COORD_W = 12;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 18;
    localparam int MEAN_W  = 12;
    localparam int THR_W   = 21;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR    = 3'd4;

    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
        logic [11:0] col;
        logic [11:0] row;
        logic        pass_kind;
        logic        frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       keyed;
    } t_pix_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_GATHER,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_DIST,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/cpk_divider.sv =====
module cpk_divider
    import cpk_pkg::*;
#(
    parameter int DEN_W = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic [SUM_W-1:0]        o_quot,
    output logic                    o_busy,
    output logic                    o_done
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quot;
    logic [DEN_W:0]    r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    n_trial;
    logic              n_ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        n_trial = {r_rem[DEN_W-1:0], r_quot[SUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_trial - {1'b0, r_den} : n_trial;
            r_quot <= {r_quot[SUM_W-2:0], n_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

// ===== hdl/color_pick_key_filter_unit.sv =====
// color pick key filter: pixels arrive as yuv with their column and row. a
// gather-pass transaction (pass_kind 0) converts the pixel to rgb (bt.601,
// fixed point with FRAC_BITS fraction bits) and adds it to window sums when it
// lies strictly inside the window around (center_x, center_y); it produces no
// output. a key-pass transaction (pass_kind 1) produces one output: the
// clamped rgb when the window is not empty and its squared distance to the
// window mean is below distance_threshold, otherwise gray (y,y,y). one shared
// multiplier does every product, so the input is ready only in the idle state.
// a gather pixel holds the input off after its accept for the five conversion
// products, the landing of the last product and the window update, so a new
// pixel is taken only once the last one is through. a key pixel then adds the
// distance steps (three squares and a drain) and an emit step; the emit step
// repeats while an earlier result still waits in the output register. the
// first key pixel after a gather pass also forms the mean with one bit-serial
// divider: three divisions, each of start, 40 quotient bits, done and store.
module color_pick_key_filter_unit
    import cpk_pkg::*;
#(
    parameter int FRAC_BITS  = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pix_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pix_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);
    // coefficients round(c * 2^FRAC_BITS)
    localparam int K_Y  = ((1164 << FRAC_BITS) + 500) / 1000;
    localparam int K_RV = ((1596 << FRAC_BITS) + 500) / 1000;
    localparam int K_GU = ((392  << FRAC_BITS) + 500) / 1000;
    localparam int K_GV = ((813  << FRAC_BITS) + 500) / 1000;
    localparam int K_BU = ((2017 << FRAC_BITS) + 500) / 1000;
    localparam int COLOR_W = 32;   // signed fixed-point colour, ample
    localparam int MUL_W = 20;     // operand width, holds the largest coefficient
    localparam int DEN_W = CNT_W + FRAC_BITS;

    // configuration
    logic [COORD_W-1:0] r_center_x, r_center_y;
    logic [7:0]         r_half_width, r_half_height;
    logic [THR_W-1:0]   r_dist_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_half_width  <= 8'd30;
            r_half_height <= 8'd15;
            r_dist_thr    <= THR_W'(8000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:    r_center_x    <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data[COORD_W-1:0];
                CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[7:0];
                CFG_HALF_HEIGHT: r_half_height <= i_cfg_data[7:0];
                CFG_DIST_THR:    r_dist_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state r_state, n_state;
    logic [2:0] r_cnt;              // product or channel index
    t_pix_in    r_pix;
    logic signed [COLOR_W-1:0] r_r, r_g, r_b;
    logic signed [SUM_W-1:0]   r_sum_r, r_sum_g, r_sum_b;
    logic [CNT_W-1:0]          r_count;
    logic signed [MEAN_W-1:0]  r_mean_r, r_mean_g, r_mean_b;
    logic                      r_mean_ready;
    logic [47:0]               r_dist_full;
    logic                      r_out_valid;
    t_pix_out                  r_out;

    // shared multiplier: signed x signed, registered product
    logic signed [MUL_W-1:0]   n_ma, n_mb;
    logic signed [2*MUL_W-1:0] r_prod;

    logic signed [9:0] dy, du, dv;
    assign dy = $signed({2'b00, r_pix.luma}) - 10'sd16;
    assign du = $signed({2'b00, r_pix.chroma_blue}) - 10'sd128;
    assign dv = $signed({2'b00, r_pix.chroma_red}) - 10'sd128;

    // nearest-integer colour (half up) for the distance
    function automatic logic signed [COLOR_W-1:0] near_int(logic signed [COLOR_W-1:0] v);
        logic signed [COLOR_W-1:0] t;
        t = v + COLOR_W'(1 <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic [7:0] out_chan(logic signed [COLOR_W-1:0] v);
        logic signed [COLOR_W-1:0] i;
        i = v >>> FRAC_BITS;
        if (v < 0) return 8'd0;
        if (i > 255) return 8'd255;
        return i[7:0];
    endfunction

    logic signed [COLOR_W-1:0] n_err;
    always_comb begin
        case (r_cnt)
            3'd0:    n_err = COLOR_W'(r_mean_r) - near_int(r_r);
            3'd1:    n_err = COLOR_W'(r_mean_g) - near_int(r_g);
            default: n_err = COLOR_W'(r_mean_b) - near_int(r_b);
        endcase
    end

    // multiplier operand selection
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        if (r_state == ST_CONV) begin
            case (r_cnt)
                3'd0:    begin n_ma = MUL_W'(K_Y);  n_mb = MUL_W'(dy); end
                3'd1:    begin n_ma = MUL_W'(K_RV); n_mb = MUL_W'(dv); end
                3'd2:    begin n_ma = MUL_W'(K_GU); n_mb = MUL_W'(du); end
                3'd3:    begin n_ma = MUL_W'(K_GV); n_mb = MUL_W'(dv); end
                default: begin n_ma = MUL_W'(K_BU); n_mb = MUL_W'(du); end
            endcase
        end else begin
            n_ma = MUL_W'(n_err);
            n_mb = MUL_W'(n_err);
        end
    end

    // divider
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [SUM_W-1:0]   div_num;
    logic [SUM_W-1:0]   div_quot;
    logic signed [SUM_W-1:0] cur_sum;
    logic [DEN_W-1:0]   den;

    always_comb begin
        case (r_cnt)
            3'd0:    cur_sum = r_sum_r;
            3'd1:    cur_sum = r_sum_g;
            default: cur_sum = r_sum_b;
        endcase
        den = {r_count, {FRAC_BITS{1'b0}}};
        // |s| + d/2, ties away from zero
        div_num = (cur_sum < 0 ? SUM_W'(-cur_sum) : SUM_W'(cur_sum))
                  + SUM_W'(den >> 1);
    end

    cpk_divider #(.DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (den),
        .o_quot  (div_quot),
        .o_busy  (div_busy),
        .o_done  (div_done)
    );

    logic signed [MEAN_W-1:0] n_mean;
    always_comb begin
        if (div_quot > SUM_W'(2048))
            n_mean = cur_sum < 0 ? -12'sd2048 : 12'sd2047;
        else if (div_quot == SUM_W'(2048))
            n_mean = cur_sum < 0 ? -12'sd2048 : 12'sd2047;
        else
            n_mean = cur_sum < 0 ? -$signed(div_quot[MEAN_W-1:0])
                                 : $signed(div_quot[MEAN_W-1:0]);
    end

    // window test, signed
    logic in_win;
    always_comb begin
        logic signed [COORD_W+2:0] c, r, cx, cy, hw, hh;
        c  = $signed({3'b000, r_pix.col});
        r  = $signed({3'b000, r_pix.row});
        cx = $signed({3'b000, r_center_x});
        cy = $signed({3'b000, r_center_y});
        hw = $signed({7'd0, r_half_width});
        hh = $signed({7'd0, r_half_height});
        in_win = (r > cy - hh) && (r < cy + hh) && (c > cx - hw) && (c < cx + hw);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid && o_in_ready) n_state = ST_CONV;
            // five products, then a step for the last one to land
            ST_CONV:      if (r_cnt == 3'd5) n_state = ST_GATHER;
            ST_GATHER: begin
                if (!r_pix.pass_kind)                n_state = ST_IDLE;
                else if (r_count == '0)             n_state = ST_EMIT;
                else if (!r_mean_ready)             n_state = ST_DIV_START;
                else                                n_state = ST_DIST;
            end
            ST_DIV_START: n_state = ST_DIV_RUN;
            ST_DIV_RUN:   if (div_done) n_state = ST_DIV_STORE;
            ST_DIV_STORE: n_state = (r_cnt == 3'd2) ? ST_DIST : ST_DIV_START;
            ST_DIST:      if (r_cnt == 3'd3) n_state = ST_EMIT;
            ST_EMIT:      if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        div_start  = (r_state == ST_DIV_START);
        o_in_ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_sum_r      <= '0;
            r_sum_g      <= '0;
            r_sum_b      <= '0;
            r_count      <= '0;
            r_mean_r     <= '0;
            r_mean_g     <= '0;
            r_mean_b     <= '0;
            r_mean_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result loads as the waiting one leaves
            if (r_state == ST_EMIT && (!r_out_valid || i_out_ready))
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) r_pix <= i_in_data;
                end
                ST_CONV: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_GATHER: begin
                    r_cnt <= '0;
                    if (!r_pix.pass_kind) begin
                        r_mean_ready <= 1'b0;
                        if (in_win) begin
                            r_sum_r <= (r_pix.frame_start ? '0 : r_sum_r) + SUM_W'(r_r);
                            r_sum_g <= (r_pix.frame_start ? '0 : r_sum_g) + SUM_W'(r_g);
                            r_sum_b <= (r_pix.frame_start ? '0 : r_sum_b) + SUM_W'(r_b);
                            r_count <= (r_pix.frame_start ? '0 : r_count) + 1'b1;
                        end else if (r_pix.frame_start) begin
                            r_sum_r <= '0;
                            r_sum_g <= '0;
                            r_sum_b <= '0;
                            r_count <= '0;
                        end
                    end
                end
                ST_DIV_STORE: begin
                    case (r_cnt)
                        3'd0:    r_mean_r <= n_mean;
                        3'd1:    r_mean_g <= n_mean;
                        default: begin
                            r_mean_b     <= n_mean;
                            r_mean_ready <= 1'b1;
                        end
                    endcase
                    r_cnt <= (r_cnt == 3'd2) ? 3'd0 : r_cnt + 1'b1;
                end
                ST_DIST: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // multiplier pipeline: product is registered and lands in the cycle after the operands
    logic r_prod_v;
    logic [2:0] r_prod_idx;
    logic r_prod_conv;
    always_ff @(posedge i_clk) begin
        r_prod      <= n_ma * n_mb;
        r_prod_v    <= (r_state == ST_CONV && r_cnt != 3'd5) ||
                       (r_state == ST_DIST && r_cnt != 3'd3);
        r_prod_idx  <= r_cnt;
        r_prod_conv <= (r_state == ST_CONV);
    end

    // accumulate products into colours and the distance
    always_ff @(posedge i_clk) begin
        if (r_prod_v && r_prod_conv) begin
            case (r_prod_idx)
                3'd0: begin
                    r_r <= COLOR_W'(r_prod);
                    r_g <= COLOR_W'(r_prod);
                    r_b <= COLOR_W'(r_prod);
                end
                3'd1: r_r <= r_r + COLOR_W'(r_prod);
                3'd2: r_g <= r_g - COLOR_W'(r_prod);
                3'd3: r_g <= r_g - COLOR_W'(r_prod);
                default: r_b <= r_b + COLOR_W'(r_prod);
            endcase
        end
        if (r_prod_v && !r_prod_conv) begin
            if (r_prod_idx == 3'd0) r_dist_full <= 48'(r_prod);
            else                    r_dist_full <= r_dist_full + 48'(r_prod);
        end
        if (r_state == ST_EMIT && (!r_out_valid || i_out_ready)) begin
            if (r_count != '0 && r_dist_full < 48'(r_dist_thr)) begin
                r_out.red   <= out_chan(r_r);
                r_out.green <= out_chan(r_g);
                r_out.blue  <= out_chan(r_b);
                r_out.keyed <= 1'b1;
            end else begin
                r_out.red   <= r_pix.luma;
                r_out.green <= r_pix.luma;
                r_out.blue  <= r_pix.luma;
                r_out.keyed <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // an input transaction is taken only from the idle state
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (r_state == ST_IDLE))
        else $error("input accepted outside idle");

    // the divider is started only while idle
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(o_out_data)))
        else $error("pending result lost");
`endif
endmodule
